FILE: design/mfh_pkg.sv
`default_nettype none

package mfh_pkg;

  // Longest remaining-length field the MQTT standard allows
  localparam int MAX_LENGTH_BYTES_DEF = 4;

  localparam int LEN_W   = 28;
  localparam int TOTAL_W = 29;
  localparam int CNT_W   = 3;
  localparam int SIZE_W  = 3;

  // Parser phases
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE  = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  localparam logic [3:0] TYPE_RESERVED = 4'd0;

  typedef struct packed {
    logic [1:0]       phase;
    logic [3:0]       held_type;
    logic [3:0]       held_flags;
    logic [LEN_W-1:0] length_accumulator;
    logic [CNT_W-1:0] length_byte_count;
    logic [LEN_W-1:0] body_bytes_left;
  } mfh_state_t;

  typedef struct packed {
    logic [3:0]         packet_type;
    logic [3:0]         header_flags;
    logic [SIZE_W-1:0]  header_size;
    logic [TOTAL_W-1:0] total_length;
    logic [1:0]         status;
  } mfh_result_t;

endpackage

`default_nettype wire

FILE: design/mfh_step.sv
`default_nettype none

module mfh_step #(
  parameter int MAX_LENGTH_BYTES = mfh_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  wire logic [7:0]          data_byte,
  input  wire mfh_pkg::mfh_state_t state,
  output mfh_pkg::mfh_state_t      state_next,
  output mfh_pkg::mfh_result_t     result,
  output logic                     result_fire
);
  import mfh_pkg::*;

  logic [6:0]        b7;
  logic [LEN_W-1:0]  part;
  logic [LEN_W-1:0]  acc_new;
  logic [CNT_W-1:0]  cnt_inc;
  logic [SIZE_W-1:0] size;
  logic [LEN_W-1:0]  body_dec;

  assign b7 = data_byte[6:0];

  // 7-bit group placed at its slot, least significant group first
  always_comb begin
    case (state.length_byte_count[1:0])
      2'd0:    part = {21'd0, b7};
      2'd1:    part = {14'd0, b7, 7'd0};
      2'd2:    part = {7'd0, b7, 14'd0};
      default: part = {b7, 21'd0};
    endcase
  end

  assign acc_new  = state.length_accumulator | part;
  assign cnt_inc  = state.length_byte_count + CNT_W'(1);
  assign size     = SIZE_W'(cnt_inc) + SIZE_W'(1);
  assign body_dec = state.body_bytes_left - LEN_W'(1);

  always_comb begin
    state_next  = state;
    result_fire = 1'b0;
    result      = '0;
    unique case (state.phase)
      PH_LENGTH: begin
        state_next.length_accumulator = acc_new;
        state_next.length_byte_count  = cnt_inc;
        result.packet_type  = state.held_type;
        result.header_flags = state.held_flags;
        result.header_size  = size;
        if (!data_byte[7]) begin
          result_fire         = 1'b1;
          result.total_length = TOTAL_W'(size) + TOTAL_W'(acc_new);
          result.status       = ST_OK;
          state_next.body_bytes_left = acc_new;
          state_next.phase = (acc_new != '0) ? PH_BODY : PH_FIRST;
        end else if (cnt_inc >= CNT_W'(MAX_LENGTH_BYTES)) begin
          result_fire         = 1'b1;
          result.total_length = '0;
          result.status       = ST_MALFORMED;
          state_next.phase    = PH_FIRST;
        end
      end
      PH_BODY: begin
        state_next.body_bytes_left = body_dec;
        if (body_dec == '0) begin
          state_next.phase = PH_FIRST;
        end
      end
      default: begin
        // first byte; the unused phase code lands here too
        state_next.phase = PH_FIRST;
        if (data_byte[7:4] == TYPE_RESERVED) begin
          result_fire         = 1'b1;
          result.packet_type  = TYPE_RESERVED;
          result.header_flags = data_byte[3:0];
          result.header_size  = SIZE_W'(1);
          result.total_length = '0;
          result.status       = ST_BAD_TYPE;
        end else begin
          state_next.held_type          = data_byte[7:4];
          state_next.held_flags         = data_byte[3:0];
          state_next.length_accumulator = '0;
          state_next.length_byte_count  = '0;
          state_next.phase              = PH_LENGTH;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/mfh_result_reg.sv
`default_nettype none

module mfh_result_reg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire mfh_pkg::mfh_result_t result,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output mfh_pkg::mfh_result_t      held
);
  import mfh_pkg::*;

  logic out_valid_next;

  // a load is only issued when the slot is free or being drained
  assign out_valid_next = load | (out_valid & ~out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

`default_nettype wire

FILE: design/mqtt_fixed_header_parser_unit.sv
// A byte is taken into the input beat register, parsed from there, and its
// result, if any, is loaded into the output register.
// Throughput: one byte per cycle. A byte that makes a result waits only while
// the output register holds a stalled result; bytes with no result never wait.
// Reset (synchronous, rst high): parser state cleared, waiting for a first
// byte, out_valid low.
`default_nettype none

module mqtt_fixed_header_parser_unit #(
  parameter int MAX_LENGTH_BYTES = mfh_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       packet_type,
  output logic [3:0]       header_flags,
  output logic [2:0]       header_size,
  output logic [28:0]      total_length,
  output logic [1:0]       status
);
  import mfh_pkg::*;

  // input beat register
  logic       byte_valid;
  logic [7:0] byte_q;

  // parser state and its update
  mfh_state_t  state;
  mfh_state_t  state_next;
  mfh_result_t step_result;
  logic        step_fire;
  mfh_result_t res;

  logic advance;
  logic load;

  mfh_step #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_step (
    .data_byte  (byte_q),
    .state      (state),
    .state_next (state_next),
    .result     (step_result),
    .result_fire(step_fire)
  );

  // A held byte moves on unless it makes a result and the output slot is
  // still full and stalled. Body bytes never wait, nor do continuation bytes before the last allowed one.
  assign advance  = byte_valid & (~step_fire | ~out_valid | out_ready);
  assign load     = advance & step_fire;
  assign in_ready = ~byte_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_FIRST, default: '0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  mfh_result_reg u_result (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .result   (step_result),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .held     (res)
  );

  assign packet_type  = res.packet_type;
  assign header_flags = res.header_flags;
  assign header_size  = res.header_size;
  assign total_length = res.total_length;
  assign status       = res.status;

  // Skipping a body always has bytes left to skip
  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_BODY) |-> (state.body_bytes_left != '0))
    else $error("body phase with nothing left to skip");

  // Good header: at least one length byte, total covers the header
  a_ok_sizes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK) |->
      (header_size >= 3'd2 && total_length >= 29'(header_size)))
    else $error("ok result with bad size");

  // Bad type result comes from a single byte and carries no length
  a_bad_type: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_BAD_TYPE) |->
      (packet_type == TYPE_RESERVED && header_size == 3'd1 && total_length == '0))
    else $error("bad type result malformed");

  // Malformed length only after the full run of length bytes
  a_malformed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_MALFORMED) |->
      (header_size == 3'(MAX_LENGTH_BYTES + 1) && total_length == '0))
    else $error("malformed result with wrong size");

  // A stalled result must not be overwritten by a new one
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !load)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

FILE: tb/mfh_header_checker.sv
`timescale 1ns / 1ps

module mfh_header_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic [3:0]                  packet_type,
  input  wire logic [3:0]                  header_flags,
  input  wire logic [mfh_pkg::SIZE_W-1:0]  header_size,
  input  wire logic [mfh_pkg::TOTAL_W-1:0] total_length,
  input  wire logic [1:0]                  status,
  output int                               fail_count,
  output int                               results_due
);
  import mfh_pkg::*;

  localparam int MAX_LEN_BYTES = MAX_LENGTH_BYTES_DEF;

  // parser state as seen from the byte stream
  logic [1:0]       stage;
  logic [3:0]       cur_type;
  logic [3:0]       cur_flags;
  logic [LEN_W-1:0] len_acc;
  logic [CNT_W-1:0] len_cnt;
  logic [LEN_W-1:0] body_left;

  mfh_result_t header_results_due[$];
  int          mismatches = 0;

  // append one predicted result at the tail
  task automatic add_due(input mfh_result_t r);
    header_results_due.insert(header_results_due.size(), r);
  endtask

  task automatic parse_byte(input logic [7:0] b);
    mfh_result_t      r;
    logic [CNT_W-1:0] cnt;
    int unsigned      grp;
    logic [SIZE_W-1:0] size;
    case (stage)
      PH_LENGTH: begin
        grp = (len_cnt < 4) ? len_cnt : 3;
        len_acc = len_acc | (LEN_W'(b[6:0]) << (7 * grp));
        cnt = len_cnt + 1'b1;
        len_cnt = cnt;
        size = SIZE_W'(cnt) + 1'b1;
        r.packet_type  = cur_type;
        r.header_flags = cur_flags;
        r.header_size  = size;
        if (!b[7]) begin
          r.total_length = TOTAL_W'(size) + TOTAL_W'(len_acc);
          r.status = ST_OK;
          add_due(r);
          if (len_acc != '0) begin
            body_left = len_acc;
            stage = PH_BODY;
          end else begin
            stage = PH_FIRST;
          end
        end else if (cnt >= MAX_LEN_BYTES) begin
          // continuation still set on the last allowed length byte
          r.total_length = '0;
          r.status = ST_MALFORMED;
          add_due(r);
          stage = PH_FIRST;
        end
      end
      PH_BODY: begin
        body_left = body_left - 1'b1;
        if (body_left == '0) stage = PH_FIRST;
      end
      default: begin
        stage = PH_FIRST;
        if (b[7:4] == TYPE_RESERVED) begin
          r.packet_type  = TYPE_RESERVED;
          r.header_flags = b[3:0];
          r.header_size  = SIZE_W'(1);
          r.total_length = '0;
          r.status       = ST_BAD_TYPE;
          add_due(r);
        end else begin
          cur_type  = b[7:4];
          cur_flags = b[3:0];
          len_acc   = '0;
          len_cnt   = '0;
          stage     = PH_LENGTH;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    mfh_result_t want;
    if (rst) begin
      stage     = PH_FIRST;
      cur_type  = '0;
      cur_flags = '0;
      len_acc   = '0;
      len_cnt   = '0;
      body_left = '0;
      header_results_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (header_results_due.size() == 0) begin
          $error("result beat with nothing expected: type %0d status %0d",
                 packet_type, status);
          mismatches++;
        end else begin
          want = header_results_due.pop_front();
          if (packet_type !== want.packet_type) begin
            $error("packet_type: expected %0d, got %0d", want.packet_type, packet_type);
            mismatches++;
          end
          if (header_flags !== want.header_flags) begin
            $error("header_flags: expected %0d, got %0d", want.header_flags, header_flags);
            mismatches++;
          end
          if (header_size !== want.header_size) begin
            $error("header_size: expected %0d, got %0d", want.header_size, header_size);
            mismatches++;
          end
          if (total_length !== want.total_length) begin
            $error("total_length: expected %0d, got %0d", want.total_length, total_length);
            mismatches++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) parse_byte(data_byte);
    end
    fail_count  <= mismatches;
    results_due <= header_results_due.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mfh_pkg::*;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // DUT channels; every input known from time zero
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [7:0]         data_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         packet_type;
  logic [3:0]         header_flags;
  logic [SIZE_W-1:0]  header_size;
  logic [TOTAL_W-1:0] total_length;
  logic [1:0]         status;

  int fail_count;
  int results_due;

  // Idle knobs in percent: idle_pct drawn per accepted byte, stall_pct per cycle
  int idle_pct  = 0;
  int stall_pct = 0;
  int bytes_sent = 0;

  mqtt_fixed_header_parser_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .packet_type  (packet_type),
    .header_flags (header_flags),
    .header_size  (header_size),
    .total_length (total_length),
    .status       (status)
  );

  mfh_header_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .packet_type  (packet_type),
    .header_flags (header_flags),
    .header_size  (header_size),
    .total_length (total_length),
    .status       (status),
    .fail_count   (fail_count),
    .results_due  (results_due)
  );

  // Result side: ready drops at random per cycle, rate set by stall_pct
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // One beat on the byte channel. Valid stays up into the next beat unless
  // an idle gap is drawn after acceptance.
  task automatic send_byte(input logic [7:0] b);
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Header byte, remaining length in nbytes groups (padding groups are zero, i.e.
  // non-minimal encoding, with continuation set on all but the last), then the body.
  task automatic send_packet(input logic [3:0] kind, input logic [3:0] flags,
                             input int unsigned body_len, input int nbytes);
    logic [7:0] b;
    send_byte({kind, flags});
    for (int i = 0; i < nbytes; i++) begin
      b[6:0] = 7'(body_len >> (7 * i));
      b[7]   = (i < nbytes - 1);
      send_byte(b);
    end
    repeat (body_len) send_byte(8'($urandom));
  endtask

  // Header followed by a full run of length bytes, all with continuation set
  task automatic send_malformed(input logic [3:0] kind, input logic [3:0] flags);
    send_byte({kind, flags});
    repeat (MAX_LENGTH_BYTES_DEF) send_byte({1'b1, 7'($urandom)});
  endtask

  // Hold off the sender until every expected result has come back, then
  // let the DUT finish any body byte still in flight.
  // The first edge lets the checker's count catch the last accepted beat.
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);
  endtask

  // Mixed traffic: mostly well-formed packets with random content, some
  // reserved-type bytes and malformed length fields as noise.
  task automatic random_traffic(input int n_bytes);
    int          pick;
    int unsigned len;
    int          min_bytes;
    int          nbytes;
    int          stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_byte({TYPE_RESERVED, 4'($urandom)});
      end else if (pick < 14) begin
        send_malformed(4'($urandom_range(1, 15)), 4'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 60)      len = $urandom_range(0, 15);
        else if (pick < 90) len = $urandom_range(16, 127);
        else                len = $urandom_range(128, 300);
        min_bytes = (len < 128) ? 1 : 2;
        nbytes = min_bytes;
        if ($urandom_range(3) == 0)
          nbytes = $urandom_range(min_bytes, MAX_LENGTH_BYTES_DEF);
        send_packet(4'($urandom_range(1, 15)), 4'($urandom), len, nbytes);
      end
    end
  endtask

  task automatic set_idling(input int send_idle, input int recv_stall);
    idle_pct  = send_idle;
    stall_pct <= recv_stall;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reserved type with both flag extremes
    send_byte({TYPE_RESERVED, 4'h0});
    send_byte({TYPE_RESERVED, 4'hF});
    // Highest type, empty body
    send_packet(4'hF, 4'h0, 0, 1);
    // Short body whose bytes would look like headers if not skipped
    send_byte(8'h1F);
    send_byte(8'h02);
    send_byte(8'hFF);
    send_byte({TYPE_RESERVED, 4'h0});
    // Four length bytes, value zero: longest header with an empty body
    send_packet(4'h2, 4'h0, 0, MAX_LENGTH_BYTES_DEF);
    // Continuation still set on the fourth length byte
    send_byte(8'h3A);
    repeat (MAX_LENGTH_BYTES_DEF) send_byte(8'h80);
    send_byte(8'hC5);
    repeat (MAX_LENGTH_BYTES_DEF) send_byte(8'hFF);
    drain();

    // Random phases: none, sender idle, receiver stall, both
    set_idling(0, 0);
    random_traffic(260);
    drain();
    set_idling(47, 0);
    random_traffic(260);
    drain();
    set_idling(0, 47);
    random_traffic(260);
    drain();
    set_idling(38, 38);
    random_traffic(230);

    // Largest remaining length. Its body could never be sent in this run,
    // so it goes last: the parser is left skipping body bytes.
    send_byte(8'hFF);
    repeat (MAX_LENGTH_BYTES_DEF - 1) send_byte(8'hFF);
    send_byte(8'h7F);
    drain();

    if (fail_count == 0) begin
      $display("[mqtt_fixed_header_parser_unit] OK");
    end else begin
      $display("[mqtt_fixed_header_parser_unit] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("[mqtt_fixed_header_parser_unit] ERROR");
    $finish;
  end

endmodule
